// ----- src/skt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned OP_W     = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_READ    = 3'd2,
    OP_FIND    = 3'd3,
    OP_REPLACE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [KEY_W-1:0]   key_out;
    logic [INDEX_W-1:0] index_out;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  // Flags from the shared key comparator
  typedef struct packed {
    logic after;  // operand a belongs after operand b
    logic equal;  // operands match
  } cmp_t;

endpackage

`default_nettype wire

// ----- src/skt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Single-port key store, registered read data, no reset on contents
module skt_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/skt_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared key comparator: ordering test under the current direction, and match
module skt_cmp #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic [KEY_WIDTH-1:0] a_i,
  input  wire logic [KEY_WIDTH-1:0] b_i,
  input  wire logic                 descending_i,
  output skt_pkg::cmp_t             res_o
);

  logic lt;
  logic gt;

  assign lt = (a_i < b_i);
  assign gt = (a_i > b_i);

  // a goes after b: smaller in descending order, larger in ascending order
  assign res_o.after = descending_i ? lt : gt;
  assign res_o.equal = (a_i == b_i);

endmodule

`default_nettype wire

// ----- src/sorted_key_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Insert walks every entry held, remove shifts the entries behind the index, read is a
// single access, find scans from the front to the match, replace moves the entries it passes.
// One transfer at a time: the input stalls until the result goes to the output register;
// every step of a scan or shift goes through the one port of the key store.
// Reset: entry count cleared, order set to descending; key store is not cleared.
module sorted_key_table_top #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire skt_pkg::in_item_t   in_data_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output skt_pkg::out_item_t       out_data_o
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned XW  = (CW > skt_pkg::COUNT_W) ? CW : skt_pkg::COUNT_W;
  localparam int unsigned KXW = (KEY_WIDTH > skt_pkg::KEY_W) ? KEY_WIDTH : skt_pkg::KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_WRK,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] hold_q, hold_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic                 placed_q, placed_d;
  logic                 down_q, down_d;
  logic                 desc_q;
  skt_pkg::status_e     status_q, status_d;
  logic [KEY_WIDTH-1:0] kout_q, kout_d;
  logic [CW-1:0]        iout_q, iout_d;
  skt_pkg::out_item_t   out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // store port
  logic                 mem_en;
  logic                 mem_we;
  logic [CW-1:0]        mem_addr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [KEY_WIDTH-1:0] mem_rdata;

  // comparator
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  skt_pkg::cmp_t        cmp;

  // widened views for compares and output fields
  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        fill_x;
  logic [XW-1:0]        iout_x;
  logic [KXW-1:0]       key_in_x;
  logic [KXW-1:0]       kout_x;
  logic                 idx_ok;
  logic [CW-1:0]        ptr_inc;
  logic                 in_xfer;
  logic                 out_free;

  assign idx_x    = XW'(in_data_i.index);
  assign fill_x   = XW'(fill_q);
  assign iout_x   = XW'(iout_q);
  assign key_in_x = KXW'(in_data_i.key);
  assign kout_x   = KXW'(kout_q);
  assign idx_ok   = (idx_x < fill_x);
  assign ptr_inc  = ptr_q + CW'(1);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  skt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr[AW-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Replace moving toward the back tests the new key against the next entry
  assign cmp_a = (op_q == skt_pkg::OP_REPLACE && down_q) ? key_q : mem_rdata;
  assign cmp_b = (op_q == skt_pkg::OP_REPLACE && down_q) ? mem_rdata : key_q;

  skt_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .a_i          (cmp_a),
    .b_i          (cmp_b),
    .descending_i (desc_q),
    .res_o        (cmp)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    hold_d      = hold_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    placed_d    = placed_q;
    down_d      = down_q;
    status_d    = status_q;
    kout_d      = kout_q;
    iout_d      = iout_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = ptr_q;
    mem_wdata   = key_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d     = in_data_i.operation;
          key_d    = key_in_x[KEY_WIDTH-1:0];
          placed_d = 1'b0;
          down_d   = 1'b0;
          status_d = skt_pkg::ST_OK;
          kout_d   = '0;
          iout_d   = '0;
          ptr_d    = '0;
          state_d  = S_RD;
          case (in_data_i.operation)
            skt_pkg::OP_INSERT: begin
              if (fill_x >= XW'(DEPTH)) begin
                status_d = skt_pkg::ST_FULL;
                state_d  = S_DONE;
              end
            end
            skt_pkg::OP_REMOVE, skt_pkg::OP_READ, skt_pkg::OP_REPLACE: begin
              if (idx_ok) begin
                ptr_d = idx_x[CW-1:0];
              end else begin
                status_d = skt_pkg::ST_RANGE;
                state_d  = S_DONE;
              end
            end
            skt_pkg::OP_FIND: begin
              state_d = S_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // issue a read, or finish when the scan has run out
      S_RD: begin
        case (op_q)
          skt_pkg::OP_INSERT: begin
            if (ptr_q == fill_q) begin
              mem_we    = 1'b1;
              mem_wdata = placed_q ? hold_q : key_q;
              if (!placed_q) begin
                iout_d = ptr_q;
              end
              fill_d  = fill_q + CW'(1);
              state_d = S_DONE;
            end else begin
              mem_en  = 1'b1;
              state_d = S_EV;
            end
          end
          skt_pkg::OP_REMOVE: begin
            if (ptr_inc >= fill_q) begin
              fill_d  = fill_q - CW'(1);
              state_d = S_DONE;
            end else begin
              mem_en   = 1'b1;
              mem_addr = ptr_inc;
              state_d  = S_EV;
            end
          end
          skt_pkg::OP_FIND: begin
            if (ptr_q == fill_q) begin
              status_d = skt_pkg::ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              mem_en  = 1'b1;
              state_d = S_EV;
            end
          end
          skt_pkg::OP_REPLACE: begin
            if (!down_q) begin
              if (ptr_q == '0) begin
                if (placed_q) begin
                  state_d = S_WRK;
                end else begin
                  down_d = 1'b1;
                end
              end else begin
                mem_en   = 1'b1;
                mem_addr = ptr_q - CW'(1);
                state_d  = S_EV;
              end
            end else if (ptr_inc >= fill_q) begin
              state_d = S_WRK;
            end else begin
              mem_en   = 1'b1;
              mem_addr = ptr_inc;
              state_d  = S_EV;
            end
          end
          default: begin
            // read
            mem_en  = 1'b1;
            state_d = S_EV;
          end
        endcase
      end

      // read data is back: compare, shift one entry
      S_EV: begin
        state_d = S_RD;
        case (op_q)
          skt_pkg::OP_INSERT: begin
            if (placed_q) begin
              mem_we    = 1'b1;
              mem_wdata = hold_q;
              hold_d    = mem_rdata;
            end else if (cmp.after) begin
              mem_we    = 1'b1;
              mem_wdata = key_q;
              hold_d    = mem_rdata;
              placed_d  = 1'b1;
              iout_d    = ptr_q;
            end
            ptr_d = ptr_inc;
          end
          skt_pkg::OP_REMOVE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            ptr_d     = ptr_inc;
          end
          skt_pkg::OP_FIND: begin
            if (cmp.equal) begin
              iout_d  = ptr_q;
              state_d = S_DONE;
            end else begin
              ptr_d = ptr_inc;
            end
          end
          skt_pkg::OP_REPLACE: begin
            if (cmp.after) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata;
              if (down_q) begin
                ptr_d = ptr_inc;
              end else begin
                ptr_d    = ptr_q - CW'(1);
                placed_d = 1'b1;
              end
            end else if (!down_q && !placed_q) begin
              // already in order toward the front, try the back
              down_d = 1'b1;
            end else begin
              state_d = S_WRK;
            end
          end
          default: begin
            kout_d  = mem_rdata;
            state_d = S_DONE;
          end
        endcase
      end

      // drop the replacing key into its slot
      S_WRK: begin
        mem_we    = 1'b1;
        mem_wdata = key_q;
        iout_d    = ptr_q;
        state_d   = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_d.status    = status_q;
          out_d.key_out   = kout_x[skt_pkg::KEY_W-1:0];
          out_d.index_out = iout_x[skt_pkg::INDEX_W-1:0];
          out_d.count     = fill_x[skt_pkg::COUNT_W-1:0];
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      key_q       <= '0;
      hold_q      <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      placed_q    <= 1'b0;
      down_q      <= 1'b0;
      status_q    <= skt_pkg::ST_OK;
      kout_q      <= '0;
      iout_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      key_q       <= key_d;
      hold_q      <= hold_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      placed_q    <= placed_d;
      down_q      <= down_d;
      status_q    <= status_d;
      kout_q      <= kout_d;
      iout_q      <= iout_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b1;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(fill_q) <= XW'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_fill_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != $past(fill_q) |-> $past(state_q) == S_RD)
    else $error("entry count changed outside a scan step");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != S_IDLE && state_q != S_DONE)
    else $error("key store written while idle");

endmodule

`default_nettype wire
